// ===== rtl/core/cartesian_to_polar_angle_units_defines.svh =====
// Assertion macros for the cartesian to polar block
`ifndef CARTESIAN_TO_POLAR_ANGLE_UNITS_DEFINES_SVH
`define CARTESIAN_TO_POLAR_ANGLE_UNITS_DEFINES_SVH
// assert a property on the rising clock, quiet during reset
`define C2P_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// assert that a condition implies a later one in the next cycle
`define C2P_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

// ===== rtl/core/c2p_pkg.sv =====
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared widths, constants and the arctangent table of the cartesian to polar
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package c2p_pkg;
    localparam int CW      = 16;
    localparam int NSTG    = 20;
    localparam int GUARD   = 58 - CW;
    localparam int RW      = CW + 2;
    localparam int VW      = CW + GUARD + 3;
    localparam int ACW     = 34;
    localparam int SQW     = 2 * CW + 1;
    localparam int SQRW    = CW + 1;

    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [31:0] TURN_EIGHTH  = 32'h2000_0000;
    localparam logic [31:0] TURN_HALF    = 32'h8000_0000;

    typedef enum logic [1:0] {
        K_ZERO  = 2'd0,
        K_AXIS  = 2'd1,
        K_DIAG  = 2'd2,
        K_CORD  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       swap;
        logic       xneg;
        logic       yneg;
    } t_octant;

    function automatic logic [31:0] atan_lut(input int i);
        logic [31:0] t [0:31];
        t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
              32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
              32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
              32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
              32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
              32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
        return t[i];
    endfunction

    // unsigned angle of the octant result to the clockwise bearing
    function automatic logic [9:0] to_bearing(input logic [31:0] t0, input t_octant o);
        logic [31:0] th;
        logic [31:0] b;
        if (!o.xneg && !o.yneg) th = t0;
        else if (o.xneg && !o.yneg) th = TURN_HALF - t0;
        else if (o.xneg) th = TURN_HALF + t0;
        else th = 32'd0 - t0;
        b = TURN_QUARTER - th;
        return b[31:22];
    endfunction

    function automatic logic [31:0] octant_angle(input logic [ACW-1:0] acc,
                                                 input t_octant o);
        logic [31:0] a;
        if ($signed(acc) < 34'sd1) a = 32'd1;
        else if ($signed(acc) > $signed({2'b00, TURN_EIGHTH - 32'd1}))
            a = TURN_EIGHTH - 32'd1;
        else a = acc[31:0];
        case (o.kind)
            K_ZERO:  octant_angle = 32'd0;
            K_AXIS:  octant_angle = TURN_QUARTER;
            K_DIAG:  octant_angle = TURN_EIGHTH;
            default: octant_angle = o.swap ? TURN_QUARTER - a : a;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/cartesian_to_polar_angle_units.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_polar_angle_units
// Converts (x, y, z) to planar distance, clockwise bearing from +y in 1024
// steps per turn, and in normal mode azimuth and elevation.
// ----------------------------------------------------------------------------
// One item enters every cycle while the pipe is not stalled. Its path is
// 1 squaring stage, a square root (input register plus 17 bit stages), a
// CORDIC on the pair (distance, z), and a final formatting register. The
// planar bearing CORDIC takes its input alongside the last root bit stage,
// runs beside the second CORDIC, and its bearing is held one more
// register. The whole pipe moves as one; a stall on the output freezes it
// when the output register is full.
`default_nettype none
`include "cartesian_to_polar_angle_units_defines.svh"
module cartesian_to_polar_angle_units
    import c2p_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_func,
    input  wire logic signed [CW-1:0]  i_coord_x,
    input  wire logic signed [CW-1:0]  i_coord_y,
    input  wire logic signed [CW-1:0]  i_coord_z,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [15:0]                o_distance,
    output logic [9:0]                 o_bearing,
    output logic signed [15:0]         o_z_out,
    output logic [7:0]                 o_azimuth,
    output logic signed [8:0]          o_elevation
);
    localparam int LSQ = SQRW + 1;
    localparam int LC  = NSTG + 2;

    logic                  adv;
    logic                  r_vld1;
    logic signed [CW-1:0]  r_x1, r_y1;
    logic [SQW-1:0]        r_sq2;
    logic                  r_vld2;
    logic                  sq_valid;
    logic [SQRW-1:0]       sq_root;
    logic [9:0]            b1_late;
    logic [9:0]            b2;
    logic [2*CW-1:0]       n_xx, n_yy;

    logic                  r_func [0:LSQ+1+LC];
    logic signed [CW-1:0]  r_z    [0:LSQ+1+LC];
    logic signed [CW-1:0]  r_xd   [0:LSQ-1];
    logic signed [CW-1:0]  r_yd   [0:LSQ-1];
    logic [SQRW-1:0]       r_root [0:LC-1];
    logic [9:0]            r_b1;

    logic                  r_ovld;
    logic                  r_tvld [0:LC-1];

    assign adv     = !(r_ovld && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (adv) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_comb begin
        n_xx = (2*CW)'(r_x1) * (2*CW)'(r_x1);
        n_yy = (2*CW)'(r_y1) * (2*CW)'(r_y1);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x1 <= i_coord_x;
            r_y1 <= i_coord_y;
            r_func[0] <= i_func;
            r_z[0]    <= i_coord_z;
            r_func[1] <= r_func[0];
            r_z[1]    <= r_z[0];
            r_sq2     <= {1'b0, n_xx} + {1'b0, n_yy};
            r_xd[0]   <= r_x1;
            r_yd[0]   <= r_y1;
        end
    end

    for (genvar i = 2; i < LSQ + 2 + LC; i++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_func[i] <= r_func[i-1];
                r_z[i]    <= r_z[i-1];
            end
        end
    end

    for (genvar i = 1; i < LSQ; i++) begin : g_xy
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_xd[i] <= r_xd[i-1];
                r_yd[i] <= r_yd[i-1];
            end
        end
    end

    c2p_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_vld2),
        .i_sq    (r_sq2),
        .o_valid (sq_valid),
        .o_root  (sq_root)
    );

    // planar bearing, its input taken alongside the last root bit stage
    c2p_cordic u_cord_xy (
        .i_clk     (i_clk),
        .i_adv     (adv),
        .i_x       (RW'(r_xd[LSQ-1])),
        .i_y       (RW'(r_yd[LSQ-1])),
        .o_bearing (b1_late)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_root[0] <= sq_root;
        end
    end

    for (genvar i = 1; i < LC; i++) begin : g_root
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_root[i] <= r_root[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1 <= b1_late;
        end
    end

    c2p_cordic u_cord_dz (
        .i_clk     (i_clk),
        .i_adv     (adv),
        .i_x       ({1'b0, sq_root}),
        .i_y       (RW'(r_z[LSQ+1])),
        .o_bearing (b2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LC; i++) r_tvld[i] <= 1'b0;
        end else if (adv) begin
            r_tvld[0] <= sq_valid;
            for (int i = 1; i < LC; i++) r_tvld[i] <= r_tvld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_ovld <= r_tvld[LC-1];
        end
    end

    logic [9:0]        fin_b1;
    logic [SQRW-1:0]   fin_root;
    logic              fin_func;
    logic signed [10:0] n_el;

    assign fin_b1   = r_b1;
    assign fin_root = r_root[LC-1];
    assign fin_func = r_func[LSQ + 1 + LC];

    always_comb begin
        n_el = (11'($signed({1'b0, b2})) - 11'sd512) / 11'sd2;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_distance <= fin_root[SQRW-1] ? 16'hFFFF : fin_root[15:0];
            o_bearing  <= fin_b1;
            o_z_out    <= r_z[LSQ + 1 + LC];
            if (fin_func) begin
                o_azimuth   <= fin_b1[9:2];
                o_elevation <= (b2 == 10'd0) ? 9'sd255 : n_el[8:0];
            end else begin
                o_azimuth   <= '0;
                o_elevation <= '0;
            end
        end
    end

    assign o_valid = r_ovld;

    `C2P_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_distance), "stalled result changed")
    `C2P_ASSERT(a_stall, i_clk, i_rst_n, o_stall == (o_valid && i_stall), "stall not tied to full output")
    `C2P_ASSERT(a_az, i_clk, i_rst_n, !o_valid || o_azimuth == 8'd0 || o_azimuth == o_bearing[9:2], "azimuth disagrees with bearing")
endmodule
`default_nettype wire

// ===== rtl/core/c2p_sqrt.sv =====
// ----------------------------------------------------------------------------
// c2p_sqrt
// Pipelined restoring square root, one result bit per stage, with a
// valid bit carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none
module c2p_sqrt
    import c2p_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic              i_valid,
    input  wire logic [SQW-1:0]    i_sq,
    output logic                   o_valid,
    output logic [SQRW-1:0]        o_root
);
    localparam int NB = SQRW;

    logic [NB:0]       r_vld;
    logic [SQW+1:0]    r_rem  [0:NB];
    logic [SQRW-1:0]   r_root [0:NB];
    logic [SQW:0]      r_num  [0:NB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NB-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_num[0]  <= {1'b0, i_sq};
        end
    end

    for (genvar s = 0; s < NB; s++) begin : g_bit
        logic [SQW+1:0] n_rem;
        logic [SQW+1:0] n_trial;
        always_comb begin
            n_rem   = {r_rem[s][SQW-1:0],
                       r_num[s][2*(NB-1-s)+1],
                       r_num[s][2*(NB-1-s)]};
            n_trial = (SQW+2)'({r_root[s], 2'b01});
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_num[s+1] <= r_num[s];
                if (n_rem >= n_trial) begin
                    r_rem[s+1]  <= n_rem - n_trial;
                    r_root[s+1] <= {r_root[s][SQRW-2:0], 1'b1};
                end else begin
                    r_rem[s+1]  <= n_rem;
                    r_root[s+1] <= {r_root[s][SQRW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[NB];
    assign o_root  = r_root[NB];
endmodule
`default_nettype wire

// ===== rtl/core/c2p_cordic.sv =====
// ----------------------------------------------------------------------------
// c2p_cordic
// Pipelined vectoring CORDIC: folds a pair into the first octant, rotates
// one stage per register and delivers a 10-bit clockwise bearing.
// ----------------------------------------------------------------------------
`default_nettype none
module c2p_cordic
    import c2p_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_adv,
    input  wire logic [RW-1:0]     i_x,
    input  wire logic [RW-1:0]     i_y,
    output logic [9:0]             o_bearing
);
    logic signed [VW-1:0]  r_xv  [0:NSTG];
    logic signed [VW-1:0]  r_yv  [0:NSTG];
    logic [ACW-1:0]        r_acc [0:NSTG];
    t_octant               r_oct [0:NSTG+1];
    logic [31:0]           r_t0;

    logic signed [RW:0]    n_ax;
    logic signed [RW:0]    n_ay;
    t_octant               n_oct;

    always_comb begin
        n_ax = $signed(i_x) < 0 ? -$signed({i_x[RW-1], i_x}) : $signed({i_x[RW-1], i_x});
        n_ay = $signed(i_y) < 0 ? -$signed({i_y[RW-1], i_y}) : $signed({i_y[RW-1], i_y});
        n_oct.xneg = i_x[RW-1];
        n_oct.yneg = i_y[RW-1];
        n_oct.swap = n_ay > n_ax;
        if (n_ay == 0) n_oct.kind = K_ZERO;
        else if (n_ax == 0) n_oct.kind = K_AXIS;
        else if (n_ax == n_ay) n_oct.kind = K_DIAG;
        else n_oct.kind = K_CORD;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_oct[0] <= n_oct;
            r_acc[0] <= '0;
            if (n_oct.swap) begin
                r_xv[0] <= VW'(n_ay) <<< GUARD;
                r_yv[0] <= VW'(n_ax) <<< GUARD;
            end else begin
                r_xv[0] <= VW'(n_ax) <<< GUARD;
                r_yv[0] <= VW'(n_ay) <<< GUARD;
            end
        end
    end

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        logic signed [VW-1:0] n_dx;
        logic signed [VW-1:0] n_dy;
        always_comb begin
            n_dx = r_yv[s] >>> s;
            n_dy = r_xv[s] >>> s;
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_oct[s+1] <= r_oct[s];
                if (!r_yv[s][VW-1]) begin
                    r_xv[s+1]  <= r_xv[s] + n_dx;
                    r_yv[s+1]  <= r_yv[s] - n_dy;
                    r_acc[s+1] <= r_acc[s] + ACW'(atan_lut(s));
                end else begin
                    r_xv[s+1]  <= r_xv[s] - n_dx;
                    r_yv[s+1]  <= r_yv[s] + n_dy;
                    r_acc[s+1] <= r_acc[s] - ACW'(atan_lut(s));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_t0          <= octant_angle(r_acc[NSTG], r_oct[NSTG]);
            r_oct[NSTG+1] <= r_oct[NSTG];
        end
    end

    assign o_bearing = to_bearing(r_t0, r_oct[NSTG+1]);
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_polar_angle_units testbench
// Drives (func, x, y, z) transfers through the pipelined converter and checks
// distance, bearing, z, azimuth and elevation against a bit-exact CORDIC model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module testbench;
    import c2p_pkg::*;

    localparam int LATENCY  = 64;
    localparam int WD_LIMIT = 4000;

    typedef struct packed {
        logic [15:0]        rad;
        logic [9:0]         bear;
        logic signed [15:0] z;
        logic [7:0]         azim;
        logic signed [8:0]  elev;
    } t_polar;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_func = 1'b0;
    logic signed [CW-1:0]  i_coord_x = '0;
    logic signed [CW-1:0]  i_coord_y = '0;
    logic signed [CW-1:0]  i_coord_z = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [15:0]           o_distance;
    logic [9:0]            o_bearing;
    logic signed [15:0]    o_z_out;
    logic [7:0]            o_azimuth;
    logic signed [8:0]     o_elevation;

    t_polar expected_q[$];
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    bit     hold_off = 1'b0;
    bit     failed = 1'b0;
    int     idle_cycles = 0;

    cartesian_to_polar_angle_units DUT (.*);

    always #10 i_clk = ~i_clk;

    function automatic longint floor_shr(longint v, int s);
        return v >= 0 ? v >>> s : -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned root = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] octant_atan(longint a, longint b);
        longint xv = a <<< GUARD;
        longint yv = b <<< GUARD;
        longint acc = 0;
        longint dx, dy;
        for (int i = 0; i < NSTG && i < 32; i++) begin
            dx = floor_shr(yv, i);
            dy = floor_shr(xv, i);
            if (yv >= 0) begin
                xv += dx; yv -= dy; acc += atan_lut(i);
            end else begin
                xv -= dx; yv += dy; acc -= atan_lut(i);
            end
        end
        if (acc < 1) acc = 1;
        if (acc > longint'(TURN_EIGHTH) - 1) acc = longint'(TURN_EIGHTH) - 1;
        return acc[31:0];
    endfunction

    function automatic logic [9:0] clockwise_bearing(longint x, longint y);
        longint ax = x < 0 ? -x : x;
        longint ay = y < 0 ? -y : y;
        logic [31:0] t0, th, b;
        if (ay == 0) t0 = 0;
        else if (ax == 0) t0 = TURN_QUARTER;
        else if (ax == ay) t0 = TURN_EIGHTH;
        else if (ay < ax) t0 = octant_atan(ax, ay);
        else t0 = TURN_QUARTER - octant_atan(ay, ax);
        if (x >= 0 && y >= 0) th = t0;
        else if (x < 0 && y >= 0) th = TURN_HALF - t0;
        else if (x < 0) th = TURN_HALF + t0;
        else th = 32'd0 - t0;
        b = TURN_QUARTER - th;
        return b[31:22];
    endfunction

    function automatic t_polar convert(logic fn, logic signed [15:0] x,
                                       logic signed [15:0] y, logic signed [15:0] z);
        t_polar r;
        longint d = int_sqrt(longint'(x) * x + longint'(y) * y);
        logic [9:0] b2;
        longint e;
        r.bear = clockwise_bearing(x, y);
        r.rad = d > 65535 ? 16'hFFFF : d[15:0];
        r.z = z;
        r.azim = '0;
        r.elev = '0;
        if (fn) begin
            r.azim = r.bear[9:2];
            b2 = clockwise_bearing(d, z);
            e = (b2 == 0) ? 255 : (longint'(b2) - 512) / 2;
            r.elev = e[8:0];
        end
        return r;
    endfunction

    task automatic send_item(logic fn, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q.push_back(convert(fn, x, y, z));
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(4, 0))
            0: return 16'($urandom_range(40, 0)) - 16'sd20;
            1: return 16'($urandom_range(600, 0)) - 16'sd300;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        logic signed [15:0] v[6] = '{16'sh8000, 16'sh7FFF, -16'sd1, 16'sd0, 16'sd1, 16'sd5};
        for (int f = 0; f < 2; f++) begin
            send_item(1'(f), 16'sd0, 16'sd0, 16'sd0);
            send_item(1'(f), 16'sd0, 16'sd0, -16'sd1);
            send_item(1'(f), 16'sh8000, 16'sh8000, 16'sh7FFF);
            send_item(1'(f), 16'sh7FFF, 16'sh8001, 16'sh8000);
            send_item(1'(f), 16'sd7, -16'sd7, 16'sd3);
            send_item(1'(f), -16'sd3, 16'sd3, 16'sd0);
            for (int i = 0; i < 6; i++) send_item(1'(f), v[i], v[5 - i], v[(i + 2) % 6]);
        end
        drain();
    endtask

    task automatic test_random(int n, int idle_pct, int stall_p);
        send_idle_pct = idle_pct;
        stall_pct = stall_p;
        repeat (n) send_item(1'($urandom_range(1, 0)), rand_coord(), rand_coord(), rand_coord());
        drain();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        repeat (150) send_item(1'($urandom_range(1, 0)), rand_coord(), rand_coord(), rand_coord());
        drain();
    endtask

    always @(negedge i_clk) begin
        int hold_count;
        if (hold_off) begin
            i_stall <= 1'b1;
            hold_count++;
            if (hold_count >= 300) begin
                hold_off = 1'b0;
                hold_count = 0;
            end
        end else begin
            i_stall <= stall_pct > 0 && $urandom_range(99, 0) < stall_pct;
        end
    end

    always @(posedge i_clk) begin
        t_polar got, exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_distance, o_bearing, o_z_out, o_azimuth, o_elevation};
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transfer %p", $time, got);
                failed = 1'b1;
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("cartesian_to_polar_angle_units regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(500, 0, 0);
        test_random(400, 67, 0);
        test_random(400, 0, 67);
        test_random(500, 13, 13);
        test_backpressure();
        if (!failed && expected_q.size() == 0)
            $display("cartesian_to_polar_angle_units regression: pass");
        else
            $display("cartesian_to_polar_angle_units regression: fail");
        $finish;
    end
endmodule
